// ===== rtl/rsa_pkg.sv =====
`timescale 1ns / 1ps

package rsa_pkg;

   localparam int MAX_SECTORS   = 4096;
   localparam int END_W         = 13;
   localparam int IDX_W         = 10;
   localparam int REGION_CHUNKS = 1024;
   localparam int MAP_DEPTH     = MAX_SECTORS / 8;
   localparam int MAP_AW        = 9;
   localparam int HEADER_BYTES  = 5;
   localparam int COUNT_LIMIT   = 255;
   localparam int FIRST_DATA    = 2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_BOGUS     = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_SCAN,
      S_RNG_RD,
      S_RNG_WR,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [MAP_AW-1:0] rd_addr;
      logic              wr_en;
      logic [MAP_AW-1:0] wr_addr;
      logic              wr_load;
      logic [7:0]        wr_data;
      logic [7:0]        wr_mask;
      logic              wr_set;
   } map_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [END_W-1:0] run_start;
      logic [8:0]       run_len;
   } scan_type;

   function automatic logic [7:0] range_mask(input logic [MAP_AW-1:0] addr,
                                             input logic [END_W-1:0] lo,
                                             input logic [END_W-1:0] hi);
      logic [7:0]       m;
      logic [END_W-1:0] p;
      for (int j = 0; j < 8; j++) begin
         p    = {1'b0, addr, 3'(j)};
         m[j] = (p >= lo) && (p < hi);
      end
      return m;
   endfunction

   function automatic scan_type scan_byte(input logic [7:0]        data,
                                          input logic [MAP_AW-1:0] addr,
                                          input logic [END_W-1:0]  region_end,
                                          input logic [END_W-1:0]  need,
                                          input logic              have_old,
                                          input logic [END_W-1:0]  old_lo,
                                          input logic [END_W-1:0]  old_hi,
                                          input scan_type          cur);
      scan_type         s;
      logic [END_W-1:0] p;
      logic             used;
      s = cur;
      for (int j = 0; j < 8; j++) begin
         p = {1'b0, addr, 3'(j)};
         if (!s.found && p >= END_W'(FIRST_DATA) && p < region_end) begin
            used = data[j] && !(have_old && p >= old_lo && p < old_hi);
            if (used) begin
               s.run_start = p + END_W'(1);
               s.run_len   = '0;
            end else begin
               s.run_len = s.run_len + 9'd1;
               if ({4'b0, s.run_len} >= need) begin
                  s.found = 1'b1;
               end
            end
         end
      end
      return s;
   endfunction

endpackage

// ===== rtl/rsa_bitmap.sv =====
`timescale 1ns / 1ps

module rsa_bitmap (
   input  logic                 clock,
   input  rsa_pkg::map_ctrl_type ctrl,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [rsa_pkg::MAP_DEPTH];
   logic [7:0] q_ff;
   logic [7:0] wdata;

   always_comb begin
      if (ctrl.wr_load) begin
         wdata = ctrl.wr_data;
      end else if (ctrl.wr_set) begin
         wdata = q_ff | ctrl.wr_mask;
      end else begin
         wdata = q_ff & ~ctrl.wr_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         q_ff <= mem[ctrl.rd_addr];
      end
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wdata;
      end
   end

   assign rd_data = q_ff;

endmodule

// ===== rtl/region_sector_allocator_unit.sv =====
`timescale 1ns / 1ps

// Location table allocator for a 32x32-chunk region of 4 KiB sectors. After reset the block
// runs a clearing pass over its tables with busy high. A command is taken when start is high
// and busy is low; exactly one result beat follows on rsp_strobe, which the receiver must
// take. A read or a dropped write gives its result from the lookup state, an in-place reuse
// from the commit state. A write that needs a new run scans the used-sector bitmap one byte
// (8 sectors) per cycle up to the region end or until a free run is found, then reads and
// rewrites each bitmap byte it frees or marks (up to 33 bytes each), the old run first.

module region_sector_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [4:0]  req_chunk_x,
   input  logic [4:0]  req_chunk_z,
   input  logic [23:0] req_compressed_bytes,
   input  logic [31:0] req_write_time,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_sector_offset,
   output logic [7:0]  rsp_sector_count,
   output logic [31:0] rsp_stamp,
   output logic        rsp_reused_in_place
);

   localparam int EW = rsa_pkg::END_W;
   localparam int AW = rsa_pkg::MAP_AW;

   rsa_pkg::state_type state_ff, state_in;
   logic [rsa_pkg::IDX_W-1:0] clr_ff, clr_in;

   logic                      act_ff, act_in;
   logic [rsa_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [EW-1:0]             need_ff, need_in;
   logic [31:0]               time_ff, time_in;

   logic [31:0] loc_mem   [rsa_pkg::REGION_CHUNKS];
   logic [31:0] stamp_mem [rsa_pkg::REGION_CHUNKS];
   logic [31:0] loc_q_ff, stamp_q_ff;
   logic        tbl_re, tbl_we;
   logic [rsa_pkg::IDX_W-1:0] tbl_waddr;
   logic [31:0] tbl_wloc, tbl_wstamp;

   logic [EW-1:0] region_end_ff, region_end_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0] scan_b_ff, scan_b_in;
   logic          scan_vld_ff, scan_vld_in;
   rsa_pkg::scan_type scan_ff, scan_in, scan_nx;

   logic [EW-1:0] rng_lo_ff, rng_lo_in, rng_hi_ff, rng_hi_in;
   logic [AW-1:0] rng_addr_ff, rng_addr_in;
   logic          rng_free_ff, rng_free_in;
   logic [23:0]   target_ff, target_in;
   logic          append_ff, append_in;
   logic          reused_ff, reused_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_offset_ff, rsp_offset_in;
   logic [7:0]  rsp_count_ff, rsp_count_in;
   logic [31:0] rsp_stamp_ff, rsp_stamp_in;
   logic        rsp_reused_ff, rsp_reused_in;

   rsa_pkg::map_ctrl_type map_ctrl;
   logic [7:0]            map_q;

   logic          accept;
   logic          have_old;
   logic [23:0]   old_off;
   logic [7:0]    old_cnt;
   logic [EW-1:0] old_lo, old_hi;
   logic [AW-1:0] last_byte, rng_last;
   logic [24:0]   need_sum;
   logic [EW:0]   append_end;

   rsa_bitmap u_bitmap (
      .clock   (clock),
      .ctrl    (map_ctrl),
      .rd_data (map_q)
   );

   assign accept     = start && (state_ff == rsa_pkg::S_IDLE);
   assign busy       = (state_ff != rsa_pkg::S_IDLE);
   assign have_old   = (loc_q_ff != 32'd0);
   assign old_off    = loc_q_ff[31:8];
   assign old_cnt    = loc_q_ff[7:0];
   assign old_lo     = old_off[EW-1:0];
   assign old_hi     = old_lo + {5'b0, old_cnt};
   assign last_byte  = AW'((region_end_ff - EW'(1)) >> 3);
   assign rng_last   = AW'((rng_hi_ff - EW'(1)) >> 3);
   assign need_sum   = {1'b0, req_compressed_bytes} + 25'(rsa_pkg::HEADER_BYTES + 4095);
   assign append_end = {1'b0, region_end_ff} + {1'b0, need_ff};

   assign scan_nx = rsa_pkg::scan_byte(map_q, scan_b_ff, region_end_ff, need_ff,
                                       have_old, old_lo, old_hi, scan_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      need_in       = need_ff;
      time_in       = time_ff;
      region_end_in = region_end_ff;
      scan_addr_in  = scan_addr_ff;
      scan_b_in     = scan_b_ff;
      scan_vld_in   = 1'b0;
      scan_in       = scan_ff;
      rng_lo_in     = rng_lo_ff;
      rng_hi_in     = rng_hi_ff;
      rng_addr_in   = rng_addr_ff;
      rng_free_in   = rng_free_ff;
      target_in     = target_ff;
      append_in     = append_ff;
      reused_in     = reused_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_reused_in = rsp_reused_ff;
      tbl_re        = 1'b0;
      tbl_we        = 1'b0;
      tbl_waddr     = idx_ff;
      tbl_wloc      = {target_ff, need_ff[7:0]};
      tbl_wstamp    = time_ff;
      map_ctrl      = '0;

      case (state_ff)
         rsa_pkg::S_CLEAR: begin
            tbl_we           = 1'b1;
            tbl_waddr        = clr_ff;
            tbl_wloc         = '0;
            tbl_wstamp       = '0;
            map_ctrl.wr_en   = 1'b1;
            map_ctrl.wr_load = 1'b1;
            map_ctrl.wr_addr = clr_ff[AW-1:0];
            map_ctrl.wr_data = (clr_ff[AW-1:0] == '0) ? 8'h03 : 8'h00;
            clr_in           = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = rsa_pkg::S_IDLE;
            end
         end
         rsa_pkg::S_IDLE: begin
            if (accept) begin
               tbl_re   = 1'b1;
               act_in   = req_action;
               idx_in   = {req_chunk_z, req_chunk_x};
               need_in  = need_sum[24:12];
               time_in  = req_write_time;
               state_in = rsa_pkg::S_LOOK;
            end
         end
         rsa_pkg::S_LOOK: begin
            if (act_ff == rsa_pkg::ACT_READ) begin
               rsp_strobe_in = 1'b1;
               rsp_reused_in = 1'b0;
               state_in      = rsa_pkg::S_IDLE;
               if (!have_old) begin
                  rsp_status_in = rsa_pkg::ST_EMPTY;
                  rsp_offset_in = '0;
                  rsp_count_in  = '0;
                  rsp_stamp_in  = '0;
               end else if (old_off < 24'(rsa_pkg::FIRST_DATA) || old_cnt == 8'd0) begin
                  rsp_status_in = rsa_pkg::ST_BOGUS;
                  rsp_offset_in = '0;
                  rsp_count_in  = '0;
                  rsp_stamp_in  = stamp_q_ff;
               end else begin
                  rsp_status_in = rsa_pkg::ST_OK;
                  rsp_offset_in = old_off[11:0];
                  rsp_count_in  = old_cnt;
                  rsp_stamp_in  = stamp_q_ff;
               end
            end else if (need_ff > EW'(rsa_pkg::COUNT_LIMIT)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = rsa_pkg::ST_TOO_LARGE;
               rsp_offset_in = '0;
               rsp_count_in  = '0;
               rsp_stamp_in  = '0;
               rsp_reused_in = 1'b0;
               state_in      = rsa_pkg::S_IDLE;
            end else if (have_old && {5'b0, old_cnt} >= need_ff) begin
               target_in = old_off;
               reused_in = 1'b1;
               append_in = 1'b0;
               state_in  = rsa_pkg::S_COMMIT;
            end else begin
               reused_in         = 1'b0;
               scan_addr_in      = '0;
               scan_in.found     = 1'b0;
               scan_in.run_start = EW'(rsa_pkg::FIRST_DATA);
               scan_in.run_len   = '0;
               state_in          = rsa_pkg::S_SCAN;
            end
         end
         rsa_pkg::S_SCAN: begin
            map_ctrl.rd_en   = 1'b1;
            map_ctrl.rd_addr = scan_addr_ff;
            scan_vld_in      = 1'b1;
            scan_b_in        = scan_addr_ff;
            scan_addr_in     = scan_addr_ff + 1'b1;
            if (scan_vld_ff) begin
               scan_in = scan_nx;
               if (scan_nx.found || scan_b_ff == last_byte) begin
                  scan_vld_in = 1'b0;
                  if (scan_nx.found) begin
                     target_in = {11'b0, scan_nx.run_start};
                     append_in = 1'b0;
                  end else begin
                     target_in = {11'b0, region_end_ff};
                     append_in = 1'b1;
                  end
                  if (!scan_nx.found && append_end > (EW+1)'(rsa_pkg::MAX_SECTORS)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = rsa_pkg::ST_FULL;
                     rsp_offset_in = '0;
                     rsp_count_in  = '0;
                     rsp_stamp_in  = '0;
                     rsp_reused_in = 1'b0;
                     state_in      = rsa_pkg::S_IDLE;
                  end else if (have_old && old_cnt != 8'd0) begin
                     rng_lo_in   = old_lo;
                     rng_hi_in   = old_hi;
                     rng_addr_in = AW'(old_lo >> 3);
                     rng_free_in = 1'b1;
                     state_in    = rsa_pkg::S_RNG_RD;
                  end else begin
                     rng_lo_in   = scan_nx.found ? scan_nx.run_start : region_end_ff;
                     rng_hi_in   = rng_lo_in + need_ff;
                     rng_addr_in = AW'(rng_lo_in >> 3);
                     rng_free_in = 1'b0;
                     state_in    = rsa_pkg::S_RNG_RD;
                  end
               end
            end
         end
         rsa_pkg::S_RNG_RD: begin
            map_ctrl.rd_en   = 1'b1;
            map_ctrl.rd_addr = rng_addr_ff;
            state_in         = rsa_pkg::S_RNG_WR;
         end
         rsa_pkg::S_RNG_WR: begin
            map_ctrl.wr_en   = 1'b1;
            map_ctrl.wr_addr = rng_addr_ff;
            map_ctrl.wr_mask = rsa_pkg::range_mask(rng_addr_ff, rng_lo_ff, rng_hi_ff);
            map_ctrl.wr_set  = !rng_free_ff;
            rng_addr_in      = rng_addr_ff + 1'b1;
            state_in         = rsa_pkg::S_RNG_RD;
            if (rng_addr_ff == rng_last) begin
               if (rng_free_ff) begin
                  rng_lo_in   = target_ff[EW-1:0];
                  rng_hi_in   = target_ff[EW-1:0] + need_ff;
                  rng_addr_in = AW'(target_ff[EW-1:0] >> 3);
                  rng_free_in = 1'b0;
               end else begin
                  state_in = rsa_pkg::S_COMMIT;
               end
            end
         end
         rsa_pkg::S_COMMIT: begin
            tbl_we        = 1'b1;
            if (append_ff) begin
               region_end_in = region_end_ff + need_ff;
            end
            rsp_strobe_in = 1'b1;
            rsp_status_in = rsa_pkg::ST_OK;
            rsp_offset_in = target_ff[11:0];
            rsp_count_in  = need_ff[7:0];
            rsp_stamp_in  = time_ff;
            rsp_reused_in = reused_ff;
            state_in      = rsa_pkg::S_IDLE;
         end
         default: begin
            state_in = rsa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_re) begin
         loc_q_ff   <= loc_mem[{req_chunk_z, req_chunk_x}];
         stamp_q_ff <= stamp_mem[{req_chunk_z, req_chunk_x}];
      end
      if (tbl_we) begin
         loc_mem[tbl_waddr]   <= tbl_wloc;
         stamp_mem[tbl_waddr] <= tbl_wstamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rsa_pkg::S_CLEAR;
         clr_ff        <= '0;
         region_end_ff <= EW'(rsa_pkg::FIRST_DATA);
         scan_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         region_end_ff <= region_end_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      need_ff       <= need_in;
      time_ff       <= time_in;
      scan_addr_ff  <= scan_addr_in;
      scan_b_ff     <= scan_b_in;
      scan_ff       <= scan_in;
      rng_lo_ff     <= rng_lo_in;
      rng_hi_ff     <= rng_hi_in;
      rng_addr_ff   <= rng_addr_in;
      rng_free_ff   <= rng_free_in;
      target_ff     <= target_in;
      append_ff     <= append_in;
      reused_ff     <= reused_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_sector_offset   = rsp_offset_ff;
   assign rsp_sector_count    = rsp_count_ff;
   assign rsp_stamp           = rsp_stamp_ff;
   assign rsp_reused_in_place = rsp_reused_ff;

endmodule

// ===== rtl/rsa_checker.sv =====
`timescale 1ns / 1ps

module rsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [11:0] rsp_sector_offset,
   input logic [7:0]  rsp_sector_count,
   input logic        rsp_reused_in_place
);

   // a command keeps the unit busy until its result beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit not busy after accepting a command");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back result beats");

   a_no_beat_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_strobe)
      else $error("result beat without a command");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != rsa_pkg::ST_OK
      |-> rsp_sector_offset == '0 && rsp_sector_count == '0 && !rsp_reused_in_place)
      else $error("failed result carries a run");

   a_reuse_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_reused_in_place |-> rsp_status == rsa_pkg::ST_OK)
      else $error("reuse flagged on a failed result");

endmodule

bind region_sector_allocator_unit rsa_checker u_rsa_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_status          (rsp_status),
   .rsp_sector_offset   (rsp_sector_offset),
   .rsp_sector_count    (rsp_sector_count),
   .rsp_reused_in_place (rsp_reused_in_place)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      rsa_pkg::action_type act;
      logic [4:0]          cx;
      logic [4:0]          cz;
      logic [23:0]         bytes;
      logic [31:0]         wtime;
   } chunk_cmd_type;

   typedef struct {
      rsa_pkg::status_type status;
      logic [11:0]         offset;
      logic [7:0]          count;
      logic [31:0]         stamp;
      logic                reused;
   } placement_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [4:0]  req_chunk_x;
   logic [4:0]  req_chunk_z;
   logic [23:0] req_compressed_bytes;
   logic [31:0] req_write_time;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_sector_offset;
   logic [7:0]  rsp_sector_count;
   logic [31:0] rsp_stamp;
   logic        rsp_reused_in_place;

   region_sector_allocator_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_chunk_x(req_chunk_x), .req_chunk_z(req_chunk_z),
      .req_compressed_bytes(req_compressed_bytes), .req_write_time(req_write_time),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_sector_offset(rsp_sector_offset), .rsp_sector_count(rsp_sector_count),
      .rsp_stamp(rsp_stamp), .rsp_reused_in_place(rsp_reused_in_place)
   );

   chunk_cmd_type  pending_cmds[$];
   placement_type  expected_placements[$];
   chunk_cmd_type  cur_cmd;
   int             mismatches = 0;
   int             gap_left = 0;
   bit             quiet_tail = 0;

   // mirror of the allocator state
   logic [31:0] loc_tab[rsa_pkg::REGION_CHUNKS];
   logic [31:0] stamp_tab[rsa_pkg::REGION_CHUNKS];
   bit          sector_used[rsa_pkg::MAX_SECTORS];
   int unsigned region_end_m;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit sector_busy(int unsigned s);
      if (s >= rsa_pkg::MAX_SECTORS) return 1;
      return sector_used[s];
   endfunction

   function automatic void mark_sector(int unsigned s, bit v);
      if (s < rsa_pkg::MAX_SECTORS) sector_used[s] = v;
   endfunction

   task automatic place_chunk(input chunk_cmd_type c);
      placement_type p;
      int unsigned   idx, loc, old_off, old_cnt, need, target, run_start, run_len;
      bit            reused, found;
      bit            saved[256];
      idx     = c.cz * 32 + c.cx;
      loc     = loc_tab[idx];
      old_off = (loc >> 8) & 32'hFFFFFF;
      old_cnt = loc & 32'hFF;
      p = '{rsa_pkg::ST_OK, 12'd0, 8'd0, 32'd0, 1'b0};
      if (c.act == rsa_pkg::ACT_READ) begin
         if (loc == 0) p.status = rsa_pkg::ST_EMPTY;
         else if (old_off < rsa_pkg::FIRST_DATA || old_cnt == 0) begin
            p.status = rsa_pkg::ST_BOGUS;
            p.stamp  = stamp_tab[idx];
         end else begin
            p.offset = old_off[11:0];
            p.count  = old_cnt[7:0];
            p.stamp  = stamp_tab[idx];
         end
         expected_placements.push_back(p);
         return;
      end
      need = (int'(c.bytes) + rsa_pkg::HEADER_BYTES + 4095) / 4096;
      if (need > rsa_pkg::COUNT_LIMIT) begin
         p.status = rsa_pkg::ST_TOO_LARGE;
         expected_placements.push_back(p);
         return;
      end
      target = 0;
      reused = 0;
      if (loc != 0 && old_cnt >= need) begin
         target = old_off;
         reused = 1;
      end else begin
         found     = 0;
         run_start = rsa_pkg::FIRST_DATA;
         run_len   = 0;
         if (loc != 0)
            for (int i = 0; i < old_cnt; i++) begin
               saved[i] = sector_busy(old_off + i);
               if (old_off + i < region_end_m) mark_sector(old_off + i, 0);
            end
         for (int unsigned s = rsa_pkg::FIRST_DATA; s < region_end_m && !found; s++) begin
            if (sector_busy(s)) begin
               run_start = s + 1;
               run_len   = 0;
            end else begin
               run_len++;
               if (run_len >= need) found = 1;
            end
         end
         if (found) begin
            for (int i = 0; i < need; i++) mark_sector(run_start + i, 1);
            target = run_start;
         end else if (region_end_m + need <= rsa_pkg::MAX_SECTORS) begin
            target = region_end_m;
            for (int i = 0; i < need; i++) mark_sector(region_end_m + i, 1);
            region_end_m += need;
         end else begin
            if (loc != 0)
               for (int i = 0; i < old_cnt; i++)
                  if (old_off + i < region_end_m) mark_sector(old_off + i, saved[i]);
            p.status = rsa_pkg::ST_FULL;
            expected_placements.push_back(p);
            return;
         end
      end
      loc_tab[idx]   = ((target & 32'hFFFFFF) << 8) | (need & 32'hFF);
      stamp_tab[idx] = c.wtime;
      p.offset = target[11:0];
      p.count  = need[7:0];
      p.stamp  = c.wtime;
      p.reused = reused;
      expected_placements.push_back(p);
   endtask

   // driver
   always @(posedge clock) begin
      chunk_cmd_type nxt;
      bit            free_slot;
      if (reset) begin
         start <= 1'b0;
      end else begin
         free_slot = !start;
         if (start && !busy) begin
            place_chunk(cur_cmd);
            free_slot = 1;
            if (!quiet_tail && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
         end
         if (free_slot) begin
            if (gap_left > 0 && !quiet_tail) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               nxt = pending_cmds.pop_front();
               cur_cmd <= nxt;
               start <= 1'b1;
               req_action <= nxt.act;
               req_chunk_x <= nxt.cx;
               req_chunk_z <= nxt.cz;
               req_compressed_bytes <= nxt.bytes;
               req_write_time <= nxt.wtime;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      placement_type e;
      if (!reset && rsp_strobe) begin
         if (expected_placements.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat, status %0d", rsp_status);
         end else begin
            e = expected_placements.pop_front();
            if (rsp_status !== e.status || rsp_sector_offset !== e.offset ||
                rsp_sector_count !== e.count || rsp_stamp !== e.stamp ||
                rsp_reused_in_place !== e.reused) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d/%0d/%0d/%h/%0d got %0d/%0d/%0d/%h/%0d",
                           e.status, e.offset, e.count, e.stamp, e.reused,
                           rsp_status, rsp_sector_offset, rsp_sector_count,
                           rsp_stamp, rsp_reused_in_place);
            end
         end
      end
   end

   function automatic chunk_cmd_type mk(rsa_pkg::action_type a, int x, int z, int b,
                                        logic [31:0] t);
      chunk_cmd_type c;
      c.act = a; c.cx = x[4:0]; c.cz = z[4:0]; c.bytes = b[23:0]; c.wtime = t;
      return c;
   endfunction

   initial begin
      chunk_cmd_type c;
      int            sel;
      reset = 1; start = 0; req_action = 0; req_chunk_x = 0; req_chunk_z = 0;
      req_compressed_bytes = 0; req_write_time = 0;
      for (int i = 0; i < rsa_pkg::REGION_CHUNKS; i++) begin
         loc_tab[i] = 0; stamp_tab[i] = 0;
      end
      for (int i = 0; i < rsa_pkg::MAX_SECTORS; i++)
         sector_used[i] = (i < rsa_pkg::FIRST_DATA);
      region_end_m = rsa_pkg::FIRST_DATA;

      // directed
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 0, 0, 0, 0));
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 31, 31, 24'hFFFFFF, 32'hFFFFFFFF));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 0, 0, 0, 32'h0));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 31, 31, 4091, 32'hFFFFFFFF));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 1, 0, 4092, 32'h12345678));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 2, 0, 24'hFFFFFF, 32'h1));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 3, 0, 1044476, 32'h2));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 4, 0, 1044475, 32'h3));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 4, 0, 100, 32'h4));
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 4, 0, 0, 0));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 0, 0, 20000, 32'h5));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 5, 0, 30000, 32'h6));
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 0, 0, 0, 0));
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 31, 31, 0, 0));
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 1, 0, 0, 0));

      // random
      for (int n = 0; n < 960; n++) begin
         sel = $urandom_range(0, 99);
         c.act   = (sel < 30) ? rsa_pkg::ACT_READ : rsa_pkg::ACT_WRITE;
         if ($urandom_range(0, 1)) begin
            c.cx = 5'($urandom_range(0, 3));
            c.cz = 5'($urandom_range(0, 3));
         end else begin
            c.cx = 5'($urandom);
            c.cz = 5'($urandom);
         end
         sel = $urandom_range(0, 99);
         if (sel < 75) c.bytes = 24'($urandom_range(0, 20000));
         else if (sel < 90) c.bytes = 24'($urandom_range(0, 300000));
         else if (sel < 95) c.bytes = 24'($urandom_range(0, 1044475));
         else c.bytes = 24'($urandom);
         c.wtime = $urandom;
         pending_cmds.push_back(c);
      end

      // fill the region to the top
      for (int i = 0; i < 18; i++)
         pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, i, 20, 1044475, $urandom));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 31, 20, 1044475, 32'h7));
      pending_cmds.push_back(mk(rsa_pkg::ACT_WRITE, 0, 0, 1044475, 32'h8));
      pending_cmds.push_back(mk(rsa_pkg::ACT_READ, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 0;
      wait (pending_cmds.size() < 150);
      quiet_tail = 1;
      wait (pending_cmds.size() == 0 && !start && expected_placements.size() == 0);
      repeat (700) @(posedge clock);
      if (mismatches == 0 && expected_placements.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(64'd40_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rsa_pkg.sv
rtl/rsa_bitmap.sv
rtl/region_sector_allocator_unit.sv
rtl/rsa_checker.sv
verif/tb_top.sv
